@@ hw/rtl/paoc_pkg.sv @@
// Package for the positioned alpha-over compositor.
// Register indexes, field widths, shared structs and the divide-by-255 helper.
// No dependencies.
package paoc_pkg;

  // Field widths fixed by the register map and pixel format
  localparam int unsigned CHAN_W     = 8;
  localparam int unsigned POS_W      = 14;  // signed window position
  localparam int unsigned DIM_W      = 13;  // unsigned sizes
  localparam int unsigned CFG_DATA_W = 14;
  localparam int unsigned CFG_IDX_W  = 3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_X      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_Y      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT  = 3'd5;

  localparam logic [CHAN_W-1:0] ALPHA_OPAQUE = 8'hFF;

  // Window and frame geometry as held in the config registers
  typedef struct packed {
    logic signed [POS_W-1:0] window_x;
    logic signed [POS_W-1:0] window_y;
    logic [DIM_W-1:0]        window_width;
    logic [DIM_W-1:0]        window_height;
    logic [DIM_W-1:0]        frame_width;
    logic [DIM_W-1:0]        frame_height;
  } geom_cfg_t;

  // Per-pixel position flags from the raster tracker
  typedef struct packed {
    logic in_window;
    logic frame_end;
  } pos_flags_t;

  // floor(x / 255) for any x up to 255*255 (any 8x8 product), by add and shift
  function automatic logic [CHAN_W-1:0] div255(input logic [15:0] x);
    logic [16:0] t;
    t = {1'b0, x} + 17'd1 + {9'd0, x[15:8]};
    return t[15:8];
  endfunction

endpackage

@@ hw/rtl/paoc_if.sv @@
// Stream interfaces for the compositor: pixel input and composite output.
// Valid/ready handshake; depends on paoc_pkg for widths.
interface paoc_pixel_if;
  logic                        valid;
  logic                        ready;
  logic [paoc_pkg::CHAN_W-1:0] back_red;
  logic [paoc_pkg::CHAN_W-1:0] back_green;
  logic [paoc_pkg::CHAN_W-1:0] back_blue;
  logic [paoc_pkg::CHAN_W-1:0] fore_red;
  logic [paoc_pkg::CHAN_W-1:0] fore_green;
  logic [paoc_pkg::CHAN_W-1:0] fore_blue;
  logic [paoc_pkg::CHAN_W-1:0] fore_alpha;

  modport source (
    output valid, back_red, back_green, back_blue,
           fore_red, fore_green, fore_blue, fore_alpha,
    input  ready
  );
  modport sink (
    input  valid, back_red, back_green, back_blue,
           fore_red, fore_green, fore_blue, fore_alpha,
    output ready
  );
endinterface

interface paoc_composite_if;
  logic                        valid;
  logic                        ready;
  logic [paoc_pkg::CHAN_W-1:0] out_red;
  logic [paoc_pkg::CHAN_W-1:0] out_green;
  logic [paoc_pkg::CHAN_W-1:0] out_blue;
  logic [paoc_pkg::CHAN_W-1:0] out_alpha;
  logic                        inside_window;
  logic                        frame_end;

  modport source (
    output valid, out_red, out_green, out_blue, out_alpha, inside_window, frame_end,
    input  ready
  );
  modport sink (
    input  valid, out_red, out_green, out_blue, out_alpha, inside_window, frame_end,
    output ready
  );
endinterface

@@ hw/rtl/paoc_position.sv @@
// Raster position tracker: column/row counters and window membership test.
// Depends on paoc_pkg (geom_cfg_t, pos_flags_t).
module paoc_position #(
  parameter int unsigned MAX_DIM = 4096
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  paoc_pkg::geom_cfg_t cfg,
  output paoc_pkg::pos_flags_t flags
);

  localparam int unsigned CNT_W  = $clog2(MAX_DIM);
  localparam int unsigned MAXD_W = $clog2(MAX_DIM + 1);
  localparam int unsigned FD_W   = (MAXD_W > paoc_pkg::DIM_W) ? MAXD_W : paoc_pkg::DIM_W;
  localparam int unsigned CMP_W  =
    ((CNT_W > paoc_pkg::POS_W) ? CNT_W : paoc_pkg::POS_W) + 2;

  logic [CNT_W-1:0] column_count;
  logic [CNT_W-1:0] row_count;

  logic [FD_W-1:0] fw_raw, fh_raw, fw, fh;
  logic            last_col, last_row;

  logic signed [CMP_W-1:0] col_s, row_s, wx, wy, wx_end, wy_end;

  // Frame size: zero acts as one, above MAX_DIM saturates
  assign fw_raw = FD_W'(cfg.frame_width);
  assign fh_raw = FD_W'(cfg.frame_height);

  always_comb begin
    if (fw_raw == '0) begin
      fw = FD_W'(1);
    end else if (fw_raw > FD_W'(MAX_DIM)) begin
      fw = FD_W'(MAX_DIM);
    end else begin
      fw = fw_raw;
    end
    if (fh_raw == '0) begin
      fh = FD_W'(1);
    end else if (fh_raw > FD_W'(MAX_DIM)) begin
      fh = FD_W'(MAX_DIM);
    end else begin
      fh = fh_raw;
    end
  end

  // At or past the last column/row counts as last (frame may shrink mid-frame)
  assign last_col = ((FD_W+1)'(column_count) + (FD_W+1)'(1)) >= {1'b0, fw};
  assign last_row = ((FD_W+1)'(row_count) + (FD_W+1)'(1)) >= {1'b0, fh};

  // Window test in a signed width that holds every operand
  assign col_s  = $signed(CMP_W'(column_count));
  assign row_s  = $signed(CMP_W'(row_count));
  assign wx     = {{(CMP_W-paoc_pkg::POS_W){cfg.window_x[paoc_pkg::POS_W-1]}}, cfg.window_x};
  assign wy     = {{(CMP_W-paoc_pkg::POS_W){cfg.window_y[paoc_pkg::POS_W-1]}}, cfg.window_y};
  assign wx_end = wx + $signed(CMP_W'(cfg.window_width));
  assign wy_end = wy + $signed(CMP_W'(cfg.window_height));

  assign flags.in_window = (col_s >= wx) && (col_s < wx_end) &&
                           (row_s >= wy) && (row_s < wy_end);
  assign flags.frame_end = last_col && last_row;

  // Raster counters advance once per accepted pixel
  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (step) begin
      if (last_col) begin
        column_count <= '0;
        row_count    <= last_row ? '0 : row_count + CNT_W'(1);
      end else begin
        column_count <= column_count + CNT_W'(1);
      end
    end
  end

endmodule

@@ hw/rtl/positioned_alpha_over_compositor.sv @@
// Positioned alpha-over compositor, top level.
// Depends on paoc_pkg, paoc_if (paoc_pixel_if, paoc_composite_if), paoc_position.
//
//  Channel    Dir  Handshake      Carries
//  pixel      in   valid/ready    back RGB + unpremultiplied fore RGBA
//  composite  out  valid/ready    composited RGB, alpha 255, inside/frame_end flags
//  write_*    in   write_enable   geometry register writes, index 0..5
//
// One pixel per clock sustained while the output is not stalled; each result passes stage 1, then stage 2.
// Stage 1 registers the 8x8 products, stage 2 the divide-by-255 sums.
// Synchronous reset empties both stages and zeroes the raster counters.
// A stalled output holds; stage 1 keeps accepting until it is full too.
module positioned_alpha_over_compositor #(
  parameter int unsigned MAX_DIM = 4096
) (
  input  logic                                clk,
  input  logic                                rst,
  paoc_pixel_if.sink                          pixel,
  paoc_composite_if.source                    composite,
  input  logic                                write_enable,
  input  logic [paoc_pkg::CFG_IDX_W-1:0]      write_index,
  input  logic [paoc_pkg::CFG_DATA_W-1:0]     write_data
);

  localparam int unsigned NCH = 3;

  paoc_pkg::geom_cfg_t  cfg;
  paoc_pkg::pos_flags_t flags;

  logic accept, adv_out, adv_mul;

  // Stage 1: products
  logic                  mul_valid;
  logic [NCH-1:0][15:0]  prod_fore, prod_fore_next;
  logic [NCH-1:0][15:0]  prod_back, prod_back_next;
  logic                  mul_inside, mul_frame_end;

  logic [NCH-1:0][paoc_pkg::CHAN_W-1:0] fore, back, blend_next;
  logic [paoc_pkg::CHAN_W-1:0]          alpha_eff, alpha_inv;

  // Stage 2: result register
  logic                                 res_valid;
  logic [NCH-1:0][paoc_pkg::CHAN_W-1:0] res_color;
  logic                                 res_inside, res_frame_end;

  // Geometry registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.window_x      <= '0;
      cfg.window_y      <= '0;
      cfg.window_width  <= paoc_pkg::DIM_W'(1);
      cfg.window_height <= paoc_pkg::DIM_W'(1);
      cfg.frame_width   <= paoc_pkg::DIM_W'(1);
      cfg.frame_height  <= paoc_pkg::DIM_W'(1);
    end else if (write_enable) begin
      unique case (write_index)
        paoc_pkg::REG_WINDOW_X:      cfg.window_x      <= $signed(write_data);
        paoc_pkg::REG_WINDOW_Y:      cfg.window_y      <= $signed(write_data);
        paoc_pkg::REG_WINDOW_WIDTH:  cfg.window_width  <= write_data[paoc_pkg::DIM_W-1:0];
        paoc_pkg::REG_WINDOW_HEIGHT: cfg.window_height <= write_data[paoc_pkg::DIM_W-1:0];
        paoc_pkg::REG_FRAME_WIDTH:   cfg.frame_width   <= write_data[paoc_pkg::DIM_W-1:0];
        paoc_pkg::REG_FRAME_HEIGHT:  cfg.frame_height  <= write_data[paoc_pkg::DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline flow control
  assign adv_out     = !res_valid || composite.ready;
  assign adv_mul     = !mul_valid || adv_out;
  assign pixel.ready = adv_mul;
  assign accept      = pixel.valid && adv_mul;

  paoc_position #(
    .MAX_DIM (MAX_DIM)
  ) u_position (
    .clk   (clk),
    .rst   (rst),
    .step  (accept),
    .cfg   (cfg),
    .flags (flags)
  );

  // Outside the window the foreground is transparent black
  assign fore[0] = pixel.fore_red;
  assign fore[1] = pixel.fore_green;
  assign fore[2] = pixel.fore_blue;
  assign back[0] = pixel.back_red;
  assign back[1] = pixel.back_green;
  assign back[2] = pixel.back_blue;

  assign alpha_eff = flags.in_window ? pixel.fore_alpha : '0;
  assign alpha_inv = paoc_pkg::ALPHA_OPAQUE - alpha_eff;

  always_comb begin
    for (int i = 0; i < NCH; i++) begin
      prod_fore_next[i] = flags.in_window ? (16'(fore[i]) * 16'(alpha_eff)) : '0;
      prod_back_next[i] = 16'(back[i]) * 16'(alpha_inv);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_valid <= 1'b0;
    end else if (adv_mul) begin
      mul_valid <= pixel.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      prod_fore     <= prod_fore_next;
      prod_back     <= prod_back_next;
      mul_inside    <= flags.in_window;
      mul_frame_end <= flags.frame_end;
    end
  end

  // Stage 2: floor each product by 255 and add; sum never exceeds 255
  always_comb begin
    for (int i = 0; i < NCH; i++) begin
      blend_next[i] = paoc_pkg::div255(prod_fore[i]) + paoc_pkg::div255(prod_back[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (adv_out) begin
      res_valid <= mul_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_out && mul_valid) begin
      res_color     <= blend_next;
      res_inside    <= mul_inside;
      res_frame_end <= mul_frame_end;
    end
  end

  assign composite.valid         = res_valid;
  assign composite.out_red       = res_color[0];
  assign composite.out_green     = res_color[1];
  assign composite.out_blue      = res_color[2];
  assign composite.out_alpha     = paoc_pkg::ALPHA_OPAQUE;
  assign composite.inside_window = res_inside;
  assign composite.frame_end     = res_frame_end;

endmodule

@@ hw/rtl/paoc_checker.sv @@
// Port-level checks for the compositor, bound to the top level.
// Depends on paoc_pkg and the paoc_if interfaces.
module paoc_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        res_valid,
  input logic                        res_ready,
  input logic [paoc_pkg::CHAN_W-1:0] res_red,
  input logic [paoc_pkg::CHAN_W-1:0] res_green,
  input logic [paoc_pkg::CHAN_W-1:0] res_blue,
  input logic [paoc_pkg::CHAN_W-1:0] res_alpha,
  input logic                        res_inside,
  input logic                        res_frame_end
);

  // Every result is opaque
  a_alpha_opaque: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res_alpha == paoc_pkg::ALPHA_OPAQUE)
    else $error("composite alpha not opaque");

  // A stalled result holds its payload
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid &&
      $stable({res_red, res_green, res_blue, res_inside, res_frame_end}))
    else $error("stalled composite transaction changed");

  // A result after an empty output comes from an input transaction carried through stage 1 then stage 2
  a_two_stage_latency: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(in_valid && in_ready, 2))
    else $error("composite transaction without matching input");

  // Input never blocks while the output side is free
  a_ready_when_free: assert property (@(posedge clk) disable iff (rst)
    res_ready |-> in_ready)
    else $error("input stalled with output ready");

endmodule

bind positioned_alpha_over_compositor paoc_checker u_paoc_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (pixel.valid),
  .in_ready      (pixel.ready),
  .res_valid     (composite.valid),
  .res_ready     (composite.ready),
  .res_red       (composite.out_red),
  .res_green     (composite.out_green),
  .res_blue      (composite.out_blue),
  .res_alpha     (composite.out_alpha),
  .res_inside    (composite.inside_window),
  .res_frame_end (composite.frame_end)
);
